// ----- sv/fpcp_pkg.sv -----
`timescale 1ns / 1ps
package fpcp_pkg;

  // Default frame store depth
  localparam int FRAME_DEPTH_DEF = 16;

  // Only the first bytes of a frame take part in decoding: "PINnCv"
  localparam int STORE_LEN = 6;

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  // Reply kinds; MSG_NONE gives a single empty word
  typedef enum logic [1:0] {
    MSG_NONE = 2'd0,
    MSG_ON   = 2'd1,
    MSG_OFF  = 2'd2,
    MSG_ERR  = 2'd3
  } msg_kind_t;

  localparam int MSG_IDX_W = 4;

  // One decoded item: reply kind plus pin levels after the item
  typedef struct packed {
    msg_kind_t  kind;
    logic [7:0] pins;
  } job_t;

  // Number of words a reply kind takes
  function automatic logic [MSG_IDX_W-1:0] msg_len(input msg_kind_t kind);
    logic [MSG_IDX_W-1:0] len;
    unique case (kind)
      MSG_ON:   len = 4'd6;
      MSG_OFF:  len = 4'd9;
      MSG_ERR:  len = 4'd4;
      default:  len = 4'd1;
    endcase
    return len;
  endfunction

  // Character at position idx of a reply ("Ligado", "Desligado", "ERRO")
  function automatic logic [7:0] msg_char(input msg_kind_t kind,
                                          input logic [MSG_IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kind)
      MSG_ON: begin
        case (idx)
          4'd0:    ch = 8'h4C; // L
          4'd1:    ch = 8'h69; // i
          4'd2:    ch = 8'h67; // g
          4'd3:    ch = 8'h61; // a
          4'd4:    ch = 8'h64; // d
          default: ch = 8'h6F; // o
        endcase
      end
      MSG_OFF: begin
        case (idx)
          4'd0:    ch = 8'h44; // D
          4'd1:    ch = 8'h65; // e
          4'd2:    ch = 8'h73; // s
          4'd3:    ch = 8'h6C; // l
          4'd4:    ch = 8'h69; // i
          4'd5:    ch = 8'h67; // g
          4'd6:    ch = 8'h61; // a
          4'd7:    ch = 8'h64; // d
          default: ch = 8'h6F; // o
        endcase
      end
      MSG_ERR: begin
        case (idx)
          4'd0:    ch = 8'h45; // E
          4'd1:    ch = 8'h52; // R
          4'd2:    ch = 8'h52; // R
          default: ch = 8'h4F; // O
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/framed_pin_command_parser.sv -----
`timescale 1ns / 1ps
// Framed pin command parser.
// in_*: one received character per word (in_tdata[7:0]).
// out_*: reply words; out_tdata holds tx_byte [7:0], tx_valid [8] and the
//   pin levels [16:9]; out_tlast marks the final word caused by one input.
// Frames run from '{' to '}'. "PINnS" replies "Ligado"/"Desligado" for pin n,
// "PINnCv" sets pin n to bit 0 of v, a frame longer than FRAME_DEPTH replies
// "ERRO". Any other input gives one word with tx_valid low.
// A word accepted by the front passes the job queue and then the output
// register before its first reply word shows. Throughput: one input word
// per cycle while the four-entry job queue has room; the output side gives
// one word per cycle unless stalled; a reply has 1, 4, 6 or 9 words.
// A stalled receiver holds the output register; the queue then fills and
// in_tready drops. Reset clears framing, the stored bytes, all pins and the
// queue.
module framed_pin_command_parser #(
  parameter int FRAME_DEPTH = fpcp_pkg::FRAME_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] tx_byte, [8] tx_valid, [16:9] pin_levels
  output logic        out_tlast
);
  import fpcp_pkg::*;

  logic       q_full, q_empty, q_push, q_pop;
  job_t       push_job, head_job;
  logic [7:0] tx_byte, pins;
  logic       tx_valid;

  fpcp_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (in_tvalid),
    .rx_byte  (in_tdata),
    .rx_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  fpcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  fpcp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_tx_byte  (tx_byte),
    .out_tx_valid (tx_valid),
    .out_last     (out_tlast),
    .out_pins     (pins)
  );

  assign out_tdata = {7'b0, pins, tx_valid, tx_byte};

endmodule

// ----- sv/fpcp_front.sv -----
`timescale 1ns / 1ps
module fpcp_front #(
  parameter int FRAME_DEPTH = fpcp_pkg::FRAME_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rx_valid,
  input  logic [7:0]      rx_byte,
  output logic            rx_ready,
  input  logic            q_full,
  output logic            q_push,
  output fpcp_pkg::job_t  q_job
);
  import fpcp_pkg::*;

  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [7:0]       store_r   [STORE_LEN];
  logic [7:0]       store_nxt [STORE_LEN];
  logic [7:0]       pins_r, pins_nxt;
  msg_kind_t        kind;
  logic             accept;

  assign rx_ready = !q_full;
  assign accept   = rx_valid && rx_ready;

  // Framing, storage and decode of one word
  always_comb begin
    logic [7:0] eff [STORE_LEN];
    logic [7:0] bit_sel;
    in_frame_nxt = in_frame_r;
    fill_nxt     = fill_r;
    store_nxt    = store_r;
    pins_nxt     = pins_r;
    kind         = MSG_NONE;
    bit_sel      = 8'h00;
    for (int i = 0; i < STORE_LEN; i++) begin
      eff[i] = (fill_r == CNT_W'(i)) ? 8'h00 : store_r[i];
    end
    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == CH_LBRACE) begin
          in_frame_nxt = 1'b1;
          fill_nxt     = '0;
        end
      end else if (rx_byte == CH_RBRACE) begin
        // close: terminator zero goes in after the stored bytes
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
        for (int i = 0; i < STORE_LEN; i++) begin
          if (fill_r == CNT_W'(i)) store_nxt[i] = 8'h00;
        end
        if (eff[0] == CH_P && eff[1] == CH_I && eff[2] == CH_N &&
            eff[3] >= CH_ZERO && eff[3] <= CH_SEVEN) begin
          bit_sel = 8'h01 << eff[3][2:0];
          if (eff[4] == CH_S) begin
            kind = ((pins_r & bit_sel) != 8'h00) ? MSG_ON : MSG_OFF;
          end else if (eff[4] == CH_C) begin
            pins_nxt = eff[5][0] ? (pins_r | bit_sel) : (pins_r & ~bit_sel);
          end
        end
      end else if (fill_r < CNT_W'(FRAME_DEPTH)) begin
        // data byte; bytes past the decoded ones are counted but not stored
        for (int i = 0; i < STORE_LEN; i++) begin
          if (fill_r == CNT_W'(i)) store_nxt[i] = rx_byte;
        end
        fill_nxt = fill_r + 1'b1;
      end else begin
        // overflow drops the frame
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
        kind         = MSG_ERR;
      end
    end
  end

  assign q_push     = accept;
  assign q_job.kind = kind;
  assign q_job.pins = pins_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      fill_r     <= '0;
      pins_r     <= 8'h00;
      for (int i = 0; i < STORE_LEN; i++) store_r[i] <= 8'h00;
    end else begin
      in_frame_r <= in_frame_nxt;
      fill_r     <= fill_nxt;
      pins_r     <= pins_nxt;
      store_r    <= store_nxt;
    end
  end

endmodule

// ----- sv/fpcp_queue.sv -----
`timescale 1ns / 1ps
module fpcp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fpcp_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output fpcp_pkg::job_t  head_job,
  output logic            empty
);
  import fpcp_pkg::*;

  job_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- sv/fpcp_back.sv -----
`timescale 1ns / 1ps
module fpcp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fpcp_pkg::job_t  q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_tx_byte,
  output logic            out_tx_valid,
  output logic            out_last,
  output logic [7:0]      out_pins
);
  import fpcp_pkg::*;

  logic [MSG_IDX_W-1:0] idx_r, idx_nxt;
  logic                 valid_r;
  logic [7:0]           byte_r, pins_r;
  logic                 txv_r, last_r;
  logic                 load, word_last;

  // Load a new word whenever the queue holds a job and the output register is free or being taken
  assign load      = !q_empty && (!valid_r || out_ready);
  assign word_last = (idx_r == msg_len(q_job.kind) - 1'b1);
  assign q_pop     = load && word_last;
  assign idx_nxt   = word_last ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= msg_char(q_job.kind, idx_r);
      txv_r  <= (q_job.kind != MSG_NONE);
      last_r <= word_last;
      pins_r <= q_job.pins;
    end
  end

  assign out_valid    = valid_r;
  assign out_tx_byte  = byte_r;
  assign out_tx_valid = txv_r;
  assign out_last     = last_r;
  assign out_pins     = pins_r;

endmodule

// ----- test/tb_framed_pin_command_parser.sv -----
`timescale 1ns / 1ps
module tb_framed_pin_command_parser;
  import fpcp_pkg::*;

  localparam int DEPTH = FRAME_DEPTH_DEF;

  // Frame kinds used by the random traffic
  typedef enum int {
    FK_STATUS,
    FK_SET,
    FK_BAD_PIN,
    FK_BAD_CMD,
    FK_INNER_BRACE,
    FK_FULL_CLOSE,
    FK_OVERFLOW,
    FK_SHORT,
    FK_NOISE
  } frame_kind_t;

  // One reply word as the block should send it
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic [7:0] pins;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] tx_byte, [8] tx_valid, [16:9] pin_levels
  logic        out_tlast;

  // Parser state mirror
  bit         m_in_frame;
  int         m_fill;
  logic [7:0] m_store [DEPTH];
  logic [7:0] m_pins;

  reply_t     tx_reply_q[$];
  int         fail_cnt = 0;
  int         work_cnt = 0;
  bit         idle_on = 1'b1;

  framed_pin_command_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue one reply string, one word per character
  function automatic void push_reply(input string s);
    reply_t r;
    for (int k = 0; k < s.len(); k++) begin
      r.tx_byte  = s[k];
      r.tx_valid = 1'b1;
      r.last     = (k == s.len() - 1);
      r.pins     = m_pins;
      tx_reply_q.push_back(r);
    end
  endfunction

  // Decode a closed frame from the mirrored store
  function automatic void decode_pin_frame();
    logic [7:0] pin_ch;
    logic [7:0] cmd;
    logic [7:0] mask;
    pin_ch = m_store[3];
    cmd    = m_store[4];
    if (m_store[0] != CH_P || m_store[1] != CH_I || m_store[2] != CH_N) return;
    if (pin_ch < CH_ZERO || pin_ch > CH_SEVEN) return;
    mask = 8'd1 << (pin_ch - CH_ZERO);
    if (cmd == CH_S) begin
      if ((m_pins & mask) != 0) push_reply("Ligado");
      else push_reply("Desligado");
    end else if (cmd == CH_C) begin
      if (m_store[5][0]) m_pins = m_pins | mask;
      else m_pins = m_pins & ~mask;
    end
  endfunction

  // Advance the mirror by one received byte; useful is 0 for ignored bytes
  function automatic void apply_rx_byte(input logic [7:0] c, output bit useful);
    int     n_before;
    reply_t r;
    n_before = tx_reply_q.size();
    useful   = 1'b1;
    if (!m_in_frame) begin
      if (c == CH_LBRACE) begin
        m_in_frame = 1'b1;
        m_fill     = 0;
      end else begin
        useful = 1'b0;
      end
    end else if (c == CH_RBRACE) begin
      if (m_fill < DEPTH) m_store[m_fill] = 8'h00;
      m_in_frame = 1'b0;
      m_fill     = 0;
      decode_pin_frame();
    end else if (m_fill < DEPTH) begin
      m_store[m_fill] = c;
      m_fill++;
    end else begin
      m_in_frame = 1'b0;
      m_fill     = 0;
      push_reply("ERRO");
    end
    // No character to send: one empty word
    if (tx_reply_q.size() == n_before) begin
      r.tx_byte  = 8'h00;
      r.tx_valid = 1'b0;
      r.last     = 1'b1;
      r.pins     = m_pins;
      tx_reply_q.push_back(r);
    end
  endfunction

  // Random frame byte, never the closing brace
  function automatic logic [7:0] rand_data();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_RBRACE);
    return b;
  endfunction

  function automatic logic [7:0] rand_pin_digit();
    return 8'(CH_ZERO + $urandom_range(0, 7));
  endfunction

  // Send one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    bit useful;
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    apply_rx_byte(b, useful);
    if (useful) work_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      out_tready <= !(idle_on && $urandom_range(0, 99) < 12);
    end
  end

  // Compare each reply word with the oldest expected one
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tx_reply_q.size() == 0) begin
        $error("unexpected reply word %h", out_tdata);
        fail_cnt++;
      end else begin
        want = tx_reply_q.pop_front();
        if (out_tdata[7:0] !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, out_tdata[7:0]);
          fail_cnt++;
        end
        if (out_tdata[8] !== want.tx_valid) begin
          $error("tx_valid: expected %b, got %b", want.tx_valid, out_tdata[8]);
          fail_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          fail_cnt++;
        end
        if (out_tdata[16:9] !== want.pins) begin
          $error("pin_levels: expected %h, got %h", want.pins, out_tdata[16:9]);
          fail_cnt++;
        end
      end
    end
  end

  // Bytes outside a frame, including both extremes
  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_RBRACE);
  endtask

  // Status query, set, status query again on one pin
  task automatic test_status_and_set();
    send_text("{PIN3S}");
    send_text("{PIN3C1}");
    send_text("{PIN3S}");
  endtask

  // Random frames, each kind at least once, with a stretch free of stalls
  task automatic test_random_traffic();
    logic [7:0]  fb[$];
    frame_kind_t kind;
    int          n_frame;
    int          pos;
    int          pick;
    logic [7:0]  b;
    n_frame = 0;
    while (work_cnt < 470) begin
      idle_on = !(work_cnt >= 150 && work_cnt < 260);
      if (n_frame <= FK_NOISE) begin
        kind = frame_kind_t'(n_frame);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      kind = FK_STATUS;
        else if (pick < 65) kind = FK_SET;
        else if (pick < 70) kind = FK_BAD_PIN;
        else if (pick < 75) kind = FK_BAD_CMD;
        else if (pick < 80) kind = FK_INNER_BRACE;
        else if (pick < 85) kind = FK_FULL_CLOSE;
        else if (pick < 90) kind = FK_OVERFLOW;
        else if (pick < 95) kind = FK_SHORT;
        else                kind = FK_NOISE;
      end
      n_frame++;
      fb = {};
      if (kind != FK_NOISE) fb.push_back(CH_LBRACE);
      case (kind)
        FK_STATUS: begin
          fb.push_back(CH_P); fb.push_back(CH_I); fb.push_back(CH_N);
          fb.push_back(rand_pin_digit());
          fb.push_back(CH_S);
        end
        FK_SET: begin
          fb.push_back(CH_P); fb.push_back(CH_I); fb.push_back(CH_N);
          fb.push_back(rand_pin_digit());
          fb.push_back(CH_C);
          fb.push_back(rand_data());
          repeat ($urandom_range(0, 3)) fb.push_back(rand_data());
        end
        FK_BAD_PIN: begin
          fb.push_back(CH_P); fb.push_back(CH_I); fb.push_back(CH_N);
          do b = rand_data(); while (b >= CH_ZERO && b <= CH_SEVEN);
          fb.push_back(b);
          fb.push_back($urandom_range(0, 1) ? CH_S : CH_C);
          fb.push_back(rand_data());
        end
        FK_BAD_CMD: begin
          fb.push_back(CH_P); fb.push_back(CH_I); fb.push_back(CH_N);
          fb.push_back(rand_pin_digit());
          do b = rand_data(); while (b == CH_S || b == CH_C);
          fb.push_back(b);
          fb.push_back(rand_data());
        end
        FK_INNER_BRACE: begin
          fb.push_back(CH_P); fb.push_back(CH_I); fb.push_back(CH_N);
          fb.push_back(rand_pin_digit());
          fb.push_back($urandom_range(0, 1) ? CH_S : CH_C);
          fb.push_back(rand_data());
          pos = $urandom_range(1, 6);
          fb[pos] = CH_LBRACE;
        end
        FK_FULL_CLOSE: begin
          // Exactly a full store: closed without the zero terminator
          fb.push_back(CH_P); fb.push_back(CH_I); fb.push_back(CH_N);
          fb.push_back(rand_pin_digit());
          fb.push_back($urandom_range(0, 1) ? CH_S : CH_C);
          while (fb.size() < DEPTH + 1) fb.push_back(rand_data());
        end
        FK_OVERFLOW: begin
          while (fb.size() < DEPTH + 1) fb.push_back(rand_data());
          fb.push_back($urandom_range(0, 1) ? CH_LBRACE : rand_data());
        end
        FK_SHORT: begin
          repeat ($urandom_range(0, 4)) fb.push_back(rand_data());
        end
        default: begin
          repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      // Closing brace; after an overflow it lands outside the frame
      if (kind != FK_NOISE && (kind != FK_OVERFLOW || $urandom_range(0, 1)))
        fb.push_back(CH_RBRACE);
      foreach (fb[k]) send_byte(fb[k]);
    end
    idle_on = 1'b1;
  endtask

  // Main sequence
  initial begin
    m_in_frame = 1'b0;
    m_fill     = 0;
    m_pins     = 8'h00;
    foreach (m_store[k]) m_store[k] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_bytes();
    test_status_and_set();
    test_random_traffic();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tx_reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- framed_pin_command_parser.f -----
sv/fpcp_pkg.sv
sv/fpcp_front.sv
sv/fpcp_queue.sv
sv/fpcp_back.sv
sv/framed_pin_command_parser.sv
test/tb_framed_pin_command_parser.sv
